/* sv/lms_pkg.sv */
package lms_pkg;

  localparam int unsigned SITE_IDX_W = 15;
  localparam int unsigned SP_W       = 2;
  localparam int unsigned DIR_W      = 3;
  localparam int unsigned NLU_W      = 18;
  localparam int unsigned BETA_W     = 16;
  localparam int unsigned E_W        = 9;   // one energy, at most 350
  localparam int unsigned DE_W       = 10;  // signed energy difference

  localparam logic [BETA_W-1:0] BETA_RESET = 16'd8192;

  localparam logic [SP_W-1:0] SP_VACANT = 2'd0;
  localparam logic [SP_W-1:0] SP_RED    = 2'd1;
  localparam logic [SP_W-1:0] SP_BLUE   = 2'd2;
  localparam logic [SP_W-1:0] SP_CODE3  = 2'd3;

  localparam logic [DIR_W-1:0] DIR_J_DN = 3'd0;
  localparam logic [DIR_W-1:0] DIR_J_UP = 3'd1;
  localparam logic [DIR_W-1:0] DIR_K_DN = 3'd2;
  localparam logic [DIR_W-1:0] DIR_K_UP = 3'd3;
  localparam logic [DIR_W-1:0] DIR_I_DN = 3'd4;
  localparam logic [DIR_W-1:0] DIR_I_UP = 3'd5;

  // member/neighbour counter runs 0 (the site itself) .. 6
  localparam logic [DIR_W-1:0] NBR_LAST = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [SP_W-1:0]   species;
    logic [DIR_W-1:0]  dir;
    logic              dir_bad;
    logic [NLU_W-1:0]  nlu;
  } lms_cmd_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_WRITE,
    B_READ,
    B_READ_WAIT,
    B_RD_S,
    B_RD_T,
    B_CHECK,
    B_SCAN,
    B_DRAIN,
    B_MULT,
    B_DECIDE,
    B_WR_S,
    B_WR_T,
    B_DONE
  } back_state_e;

  // (occupied neighbours - 3 or 5)^2, zero for a vacant site
  function automatic logic [4:0] site_term(input logic [DIR_W-1:0] cnt,
                                           input logic [SP_W-1:0] sp);
    logic [4:0] e;
    e = 5'd0;
    if (sp == SP_RED) begin
      case (cnt)
        3'd0:    e = 5'd9;
        3'd1:    e = 5'd4;
        3'd2:    e = 5'd1;
        3'd3:    e = 5'd0;
        3'd4:    e = 5'd1;
        3'd5:    e = 5'd4;
        3'd6:    e = 5'd9;
        default: e = 5'd0;
      endcase
    end else if (sp != SP_VACANT) begin
      case (cnt)
        3'd0:    e = 5'd25;
        3'd1:    e = 5'd16;
        3'd2:    e = 5'd9;
        3'd3:    e = 5'd4;
        3'd4:    e = 5'd1;
        3'd5:    e = 5'd0;
        3'd6:    e = 5'd1;
        default: e = 5'd0;
      endcase
    end
    return e;
  endfunction

endpackage

/* sv/lattice_metropolis_swap_move.sv */
// Metropolis swap move on a periodic SIDE^3 lattice gas (0 vacant, 1 red, 2 blue).
// Input channel (in_valid_i / in_stall_o): one transaction is a write of a site,
// a read of a site or a move attempt towards one of six neighbours.
// Output channel (out_valid_o / out_stall_i): exactly one result per input
// transaction, in order: read value, skipped flag, accepted flag and dE.
// cfg_we_i / cfg_wdata_i load beta (13 fraction bits); write it only when idle.
// Front end: splits the site index into coordinates by reciprocal multiplication,
// a quotient step and a remainder step per axis; it takes a new transaction only
// once it has pushed the last. Back end: an ignored op or bad direction goes
// straight to its result, a write stores the site, a read waits on the registered
// read, and a move reads both sites, stops on a vacant move site, else makes the
// 98 serial reads of the single-port lattice memory (both energies are gathered in
// one sweep), then decides and, for a kept swap, makes two write-backs.
// A two-entry queue lets the front end keep accepting while the back end works.
// Reset clears control state and loads beta = 1.0; lattice contents are
// undefined until software writes them.
// A stalled result holds in the output register; the back end waits in its
// done state and the queue and front end carry on until they fill.
module lattice_metropolis_swap_move #(
  parameter int unsigned SIDE = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [14:0]       site_index_i,
  input  logic [1:0]        species_in_i,
  input  logic [2:0]        direction_i,
  input  logic [17:0]       neg_log_uniform_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        species_out_o,
  output logic              skipped_o,
  output logic              accepted_o,
  output logic signed [9:0] delta_energy_o,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i
);
  import lms_pkg::*;

  localparam int unsigned CW = $clog2(SIDE);
  localparam int unsigned AW = 3 * CW;
  localparam int unsigned QW = $bits(lms_cmd_t) + AW;

  logic [BETA_W-1:0] beta_q;

  logic              f_valid, f_ready;
  lms_cmd_t          f_cmd, b_cmd;
  logic [AW-1:0]     f_coord, b_coord;
  logic              b_valid, b_pop;
  logic [QW-1:0]     q_in, q_out;

  // inverse temperature register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q <= BETA_RESET;
    end else if (cfg_we_i) begin
      beta_q <= cfg_wdata_i;
    end
  end

  lms_front #(.SIDE(SIDE)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .site_index_i (site_index_i),
    .species_in_i (species_in_i),
    .direction_i  (direction_i),
    .nlu_i        (neg_log_uniform_i),
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd),
    .coord_o      (f_coord)
  );

  assign q_in = {f_cmd, f_coord};

  lms_fifo #(.WIDTH(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (q_in),
    .pop_valid_o  (b_valid),
    .pop_i        (b_pop),
    .pop_data_o   (q_out)
  );

  assign b_cmd   = q_out[QW-1:AW];
  assign b_coord = q_out[AW-1:0];

  lms_back #(.SIDE(SIDE)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beta_i         (beta_q),
    .cmd_valid_i    (b_valid),
    .cmd_pop_o      (b_pop),
    .cmd_i          (b_cmd),
    .coord_i        (b_coord),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .species_out_o  (species_out_o),
    .skipped_o      (skipped_o),
    .accepted_o     (accepted_o),
    .delta_energy_o (delta_energy_o)
  );

endmodule

/* sv/lms_front.sv */
module lms_front #(
  parameter int unsigned SIDE = 32,
  localparam int unsigned CW = $clog2(SIDE)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      op_i,
  input  logic [lms_pkg::SITE_IDX_W-1:0]  site_index_i,
  input  logic [lms_pkg::SP_W-1:0]        species_in_i,
  input  logic [lms_pkg::DIR_W-1:0]       direction_i,
  input  logic [lms_pkg::NLU_W-1:0]       nlu_i,
  output logic                            cmd_valid_o,
  input  logic                            cmd_ready_i,
  output lms_pkg::lms_cmd_t               cmd_o,
  output logic [3*CW-1:0]                 coord_o
);
  import lms_pkg::*;

  // floor(x / SIDE) = (x * RECIP) >> SH for every 15-bit x
  localparam int unsigned SH    = SITE_IDX_W + CW;
  localparam int unsigned MW    = SITE_IDX_W + 2;
  localparam int unsigned PW    = SITE_IDX_W + MW;
  localparam logic [MW-1:0]         RECIP   = MW'(((1 << SH) / SIDE) + 1);
  localparam logic [SITE_IDX_W-1:0] SIDE_X  = SITE_IDX_W'(SIDE);
  localparam logic [2:0]            PH_LAST = 3'd5;

  front_state_e             state_q, state_d;
  lms_cmd_t                 cmd_q;
  logic [SITE_IDX_W-1:0]    dvd_q, quot_q, quot, rem_full;
  logic [PW-1:0]            prod;
  logic [2:0]               ph_q;
  logic [3*CW-1:0]          coord_q;
  logic                     accept;

  // even phase: quotient; odd phase: remainder, quotient becomes next dividend
  assign prod     = {{MW{1'b0}}, dvd_q} * {{SITE_IDX_W{1'b0}}, RECIP};
  assign quot     = SITE_IDX_W'(prod >> SH);
  assign rem_full = dvd_q - quot_q * SIDE_X;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        if (ph_q == PH_LAST) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign accept = (state_q == F_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ph_q    <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ph_q <= '0;
      end else if (state_q == F_DIV) begin
        ph_q <= ph_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op      <= op_e'(op_i);
      cmd_q.species <= (species_in_i == SP_CODE3) ? SP_BLUE : species_in_i;
      cmd_q.dir     <= direction_i;
      cmd_q.dir_bad <= (direction_i > DIR_I_UP);
      cmd_q.nlu     <= nlu_i;
      dvd_q         <= site_index_i;
    end else if (state_q == F_DIV) begin
      if (!ph_q[0]) begin
        quot_q <= quot;
      end else begin
        dvd_q <= quot_q;
        case (ph_q[2:1])
          2'd0:    coord_q[CW-1:0]      <= rem_full[CW-1:0];
          2'd1:    coord_q[2*CW-1:CW]   <= rem_full[CW-1:0];
          default: coord_q[3*CW-1:2*CW] <= rem_full[CW-1:0];
        endcase
      end
    end
  end

  assign cmd_o   = cmd_q;
  assign coord_o = coord_q;

endmodule

/* sv/lms_fifo.sv */
module lms_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* sv/lms_back.sv */
module lms_back #(
  parameter int unsigned SIDE = 32,
  localparam int unsigned CW = $clog2(SIDE),
  localparam int unsigned AW = 3 * CW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lms_pkg::BETA_W-1:0]    beta_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_pop_o,
  input  lms_pkg::lms_cmd_t             cmd_i,
  input  logic [AW-1:0]                 coord_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lms_pkg::SP_W-1:0]      species_out_o,
  output logic                          skipped_o,
  output logic                          accepted_o,
  output logic signed [lms_pkg::DE_W-1:0] delta_energy_o
);
  import lms_pkg::*;

  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned PROD_W = BETA_W + E_W;
  localparam logic [CW-1:0] MAXC = CW'(SIDE - 1);

  // one periodic step on a packed {i, j, k} coordinate
  function automatic logic [AW-1:0] step(input logic [AW-1:0] c,
                                         input logic [DIR_W-1:0] d);
    logic [CW-1:0] ci, cj, ck;
    ck = c[CW-1:0];
    cj = c[2*CW-1:CW];
    ci = c[3*CW-1:2*CW];
    case (d)
      DIR_J_DN: cj = (cj == '0)   ? MAXC : cj - CW'(1);
      DIR_J_UP: cj = (cj == MAXC) ? '0   : cj + CW'(1);
      DIR_K_DN: ck = (ck == '0)   ? MAXC : ck - CW'(1);
      DIR_K_UP: ck = (ck == MAXC) ? '0   : ck + CW'(1);
      DIR_I_DN: ci = (ci == '0)   ? MAXC : ci - CW'(1);
      DIR_I_UP: ci = (ci == MAXC) ? '0   : ci + CW'(1);
      default:  ck = ck;
    endcase
    return {ci, cj, ck};
  endfunction

  logic [SP_W-1:0]   lattice_q [DEPTH];
  logic [SP_W-1:0]   rd_q;

  back_state_e       state_q, state_d;
  lms_cmd_t          cmd_q;
  logic [AW-1:0]     s_q;
  logic [SP_W-1:0]   vs_q, vt_q;
  logic              cb_q;
  logic [DIR_W-1:0]  m_q, n_q;
  logic              pv_q, pcb_q, pes_q, pet_q;
  logic [DIR_W-1:0]  pn_q;
  logic [SP_W-1:0]   x1_q, x2_q;
  logic [DIR_W-1:0]  cnt1_q, cnt2_q;
  logic [E_W-1:0]    e1_q, e2_q;
  logic signed [DE_W-1:0] de_q;
  logic [PROD_W-1:0] prod_q;

  logic [SP_W-1:0]   res_species_q;
  logic              res_skip_q, res_acc_q;
  logic signed [DE_W-1:0] res_de_q;
  logic              out_valid_q;
  logic [SP_W-1:0]   out_species_q;
  logic              out_skip_q, out_acc_q;
  logic signed [DE_W-1:0] out_de_q;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [SP_W-1:0]   mem_wdata;
  logic              issue, load_out, scan_last, keep;
  logic [AW-1:0]     t_addr, base, xa, scan_addr;
  logic [SP_W-1:0]   v2;
  logic              occ1, occ2, oc1, oc2;
  logic [DIR_W-1:0]  cnt1_fin, cnt2_fin;
  logic [4:0]        loc1, loc2;
  logic signed [DE_W-1:0] de;
  logic [E_W-1:0]    de_mag;

  // address generation: centre (s or t), member of its star, neighbour of member
  assign t_addr    = step(s_q, cmd_q.dir);
  assign base      = cb_q ? t_addr : s_q;
  assign xa        = (m_q == '0) ? base : step(base, m_q - 3'd1);
  assign scan_addr = (n_q == '0) ? xa : step(xa, n_q - 3'd1);
  assign scan_last = cb_q && (m_q == NBR_LAST) && (n_q == NBR_LAST);

  // read data seen before (1) and after (2) the swap
  assign v2       = pes_q ? vt_q : (pet_q ? vs_q : rd_q);
  assign occ1     = (rd_q != SP_VACANT);
  assign occ2     = (v2 != SP_VACANT);
  assign cnt1_fin = cnt1_q + {2'b00, occ1};
  assign cnt2_fin = cnt2_q + {2'b00, occ2};
  assign loc1     = site_term(cnt1_fin, x1_q);
  assign loc2     = site_term(cnt2_fin, x2_q);
  assign oc1      = pcb_q ? (vt_q != SP_VACANT) : (vs_q != SP_VACANT);
  assign oc2      = pcb_q ? (vs_q != SP_VACANT) : (vt_q != SP_VACANT);

  assign de     = $signed({1'b0, e2_q}) - $signed({1'b0, e1_q});
  assign de_mag = de[DE_W-1] ? '0 : de[E_W-1:0];
  assign keep   = de_q[DE_W-1] || (de_q == '0) || (prod_q < PROD_W'(cmd_q.nlu));

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = s_q;
    mem_wdata = vt_q;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_WRITE: state_d = B_WRITE;
            OP_READ:  state_d = B_READ;
            OP_MOVE:  state_d = cmd_i.dir_bad ? B_DONE : B_RD_S;
            default:  state_d = B_DONE;
          endcase
        end
      end
      B_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = cmd_q.species;
        state_d   = B_DONE;
      end
      B_READ:      state_d = B_READ_WAIT;
      B_READ_WAIT: state_d = B_DONE;
      B_RD_S:      state_d = B_RD_T;
      B_RD_T: begin
        mem_addr = t_addr;
        state_d  = B_CHECK;
      end
      B_CHECK: state_d = (vs_q == SP_VACANT) ? B_DONE : B_SCAN;
      B_SCAN: begin
        mem_addr = scan_addr;
        issue    = 1'b1;
        if (scan_last) begin
          state_d = B_DRAIN;
        end
      end
      B_DRAIN:  state_d = B_MULT;
      B_MULT:   state_d = B_DECIDE;
      B_DECIDE: state_d = keep ? B_WR_S : B_DONE;
      B_WR_S: begin
        mem_we    = 1'b1;
        mem_wdata = vt_q;
        state_d   = B_WR_T;
      end
      B_WR_T: begin
        mem_we    = 1'b1;
        mem_addr  = t_addr;
        mem_wdata = vs_q;
        state_d   = B_DONE;
      end
      B_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // single-port lattice store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lattice_q[mem_addr] <= mem_wdata;
    end
    rd_q <= lattice_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q         <= cmd_i;
      s_q           <= coord_i;
      res_species_q <= SP_VACANT;
      res_skip_q    <= (cmd_i.op == OP_MOVE) && cmd_i.dir_bad;
      res_acc_q     <= 1'b0;
      res_de_q      <= '0;
    end
    if (state_q == B_READ_WAIT) begin
      res_species_q <= rd_q;
    end
    if (state_q == B_RD_T) begin
      vs_q <= rd_q;
    end
    if (state_q == B_CHECK) begin
      vt_q <= rd_q;
      cb_q <= 1'b0;
      m_q  <= '0;
      n_q  <= '0;
      e1_q <= '0;
      e2_q <= '0;
      if (vs_q == SP_VACANT) begin
        res_skip_q <= 1'b1;
      end
    end
    if (issue) begin
      if (n_q == NBR_LAST) begin
        n_q <= '0;
        if (m_q == NBR_LAST) begin
          m_q  <= '0;
          cb_q <= 1'b1;
        end else begin
          m_q <= m_q + 3'd1;
        end
      end else begin
        n_q <= n_q + 3'd1;
      end
    end
    pn_q  <= n_q;
    pcb_q <= cb_q;
    pes_q <= (scan_addr == s_q);
    pet_q <= (scan_addr == t_addr);
    if (pv_q) begin
      if (pn_q == '0) begin
        x1_q   <= rd_q;
        x2_q   <= v2;
        cnt1_q <= '0;
        cnt2_q <= '0;
      end else begin
        cnt1_q <= cnt1_fin;
        cnt2_q <= cnt2_fin;
        if (pn_q == NBR_LAST) begin
          if (oc1) begin
            e1_q <= e1_q + E_W'(loc1);
          end
          if (oc2) begin
            e2_q <= e2_q + E_W'(loc2);
          end
        end
      end
    end
    if (state_q == B_MULT) begin
      de_q   <= de;
      prod_q <= beta_i * de_mag;
    end
    if (state_q == B_DECIDE) begin
      res_acc_q <= keep;
      res_de_q  <= de_q;
    end
    if (load_out) begin
      out_species_q <= res_species_q;
      out_skip_q    <= res_skip_q;
      out_acc_q     <= res_acc_q;
      out_de_q      <= res_de_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign species_out_o  = out_species_q;
  assign skipped_o      = out_skip_q;
  assign accepted_o     = out_acc_q;
  assign delta_energy_o = out_de_q;

endmodule
